// ----- sv/scpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared types and constants for the sensor command packet framer.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int LEN_W       = 16;
  localparam int SUM_W       = 16;
  localparam int ADDR_W      = 32;
  localparam int CODE_W      = 16;
  localparam int POS_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE     = 1'd1;

  // byte positions within one packet
  localparam logic [POS_W-1:0] POS_SC_HI   = 4'd0;
  localparam logic [POS_W-1:0] POS_SC_LO   = 4'd1;
  localparam logic [POS_W-1:0] POS_ADDR_3  = 4'd2;
  localparam logic [POS_W-1:0] POS_ADDR_2  = 4'd3;
  localparam logic [POS_W-1:0] POS_ADDR_1  = 4'd4;
  localparam logic [POS_W-1:0] POS_ADDR_0  = 4'd5;
  localparam logic [POS_W-1:0] POS_TYPE    = 4'd6;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 4'd7;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 4'd8;
  localparam logic [POS_W-1:0] POS_DATA    = 4'd9;
  localparam logic [POS_W-1:0] POS_SUM_HI  = 4'd10;
  localparam logic [POS_W-1:0] POS_SUM_LO  = 4'd11;

  typedef struct packed {
    logic [ADDR_W-1:0] device_address;
    logic [CODE_W-1:0] start_code;
  } cfg_t;

  // one accepted request, ready for serialization
  typedef struct packed {
    logic              close;
    logic [BYTE_W-1:0] ptype;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic [SUM_W-1:0]  sum;
  } item_t;

  // request register status toward the byte emitter
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    logic             last;
  } item_stat_t;

endpackage

// ----- sv/scpf_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_regs
// Configuration registers: device address and start code.
// ----------------------------------------------------------------------------
module scpf_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpf_pkg::CFG_DATA_W-1:0] cfg_data,
  output scpf_pkg::cfg_t                 cfg
);
  import scpf_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= 32'hFFFF_FFFF;
      cfg.start_code     <= 16'hEF01;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[ADDR_W-1:0];
        REG_START_CODE:     cfg.start_code     <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/scpf_ingest.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_ingest
// Takes input requests, tracks packet state and checksum, holds the
// current request and its byte position for the emitter.
// ----------------------------------------------------------------------------
module scpf_ingest (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [scpf_pkg::BYTE_W-1:0]  packet_type,
  input  logic [scpf_pkg::COUNT_W-1:0] payload_count,
  input  logic [scpf_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         step,
  output scpf_pkg::item_t              item,
  output scpf_pkg::item_stat_t         stat
);
  import scpf_pkg::*;

  logic [COUNT_W-1:0] bytes_left, bytes_left_next;
  logic [SUM_W-1:0]   running_sum, running_sum_next;
  logic               item_valid;
  logic [POS_W-1:0]   pos;

  logic               accept;
  logic               opening;
  logic [COUNT_W-1:0] cnt;
  logic [LEN_W-1:0]   len;
  logic [SUM_W-1:0]   base_sum;
  logic [SUM_W-1:0]   new_sum;
  logic [COUNT_W-1:0] base_left;
  logic               last;

  // last byte of the held request: data byte unless it closes the packet
  assign last = (pos == POS_SUM_LO) || (pos == POS_DATA && !item.close);

  assign in_stall = item_valid && !(step && last);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    opening = (bytes_left == '0);
    if (payload_count == '0)
      cnt = COUNT_W'(1);
    else if (payload_count > COUNT_W'(MAX_PAYLOAD))
      cnt = COUNT_W'(MAX_PAYLOAD);
    else
      cnt = payload_count;
    len       = LEN_W'(cnt) + LEN_W'(2);
    base_sum  = opening ? (SUM_W'(len[15:8]) + SUM_W'(len[7:0]) + SUM_W'(packet_type))
                        : running_sum;
    new_sum   = base_sum + SUM_W'(data_byte);
    base_left = opening ? cnt : bytes_left;
    bytes_left_next  = base_left - COUNT_W'(1);
    running_sum_next = (bytes_left_next == '0) ? '0 : new_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= '0;
      running_sum <= '0;
      item_valid  <= 1'b0;
      pos         <= POS_DATA;
    end else if (accept) begin
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      item_valid  <= 1'b1;
      pos         <= opening ? POS_SC_HI : POS_DATA;
    end else if (step) begin
      if (last)
        item_valid <= 1'b0;
      else
        pos <= pos + POS_W'(1);
    end
  end

  // payload of the held request
  always_ff @(posedge clk) begin
    if (accept) begin
      item.close <= (bytes_left_next == '0);
      item.ptype <= packet_type;
      item.len   <= len;
      item.data  <= data_byte;
      item.sum   <= new_sum;
    end
  end

  assign stat.valid = item_valid;
  assign stat.pos   = pos;
  assign stat.last  = last;

`ifndef NO_ASSERTIONS
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= COUNT_W'(MAX_PAYLOAD))
    else $error("bytes_left above max payload");
  a_idle_sum_zero: assert property (@(posedge clk) disable iff (rst)
    bytes_left == '0 |-> running_sum == '0)
    else $error("checksum not cleared at packet end");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> pos <= POS_SUM_LO)
    else $error("byte position out of range");
  a_sum_only_on_close: assert property (@(posedge clk) disable iff (rst)
    item_valid && pos > POS_DATA |-> item.close)
    else $error("checksum byte on a request that does not close the packet");
`endif

endmodule

// ----- sv/scpf_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_emit
// Selects the packet byte for the current position and drives the
// output register.
// ----------------------------------------------------------------------------
module scpf_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  scpf_pkg::cfg_t              cfg,
  input  scpf_pkg::item_t             item,
  input  scpf_pkg::item_stat_t        stat,
  output logic                        step,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scpf_pkg::BYTE_W-1:0] out_byte,
  output logic                        run_last,
  output logic                        packet_end
);
  import scpf_pkg::*;

  logic [BYTE_W-1:0] sel_byte;

  assign step = stat.valid && (!out_valid || !out_stall);

  always_comb begin
    case (stat.pos)
      POS_SC_HI:  sel_byte = cfg.start_code[15:8];
      POS_SC_LO:  sel_byte = cfg.start_code[7:0];
      POS_ADDR_3: sel_byte = cfg.device_address[31:24];
      POS_ADDR_2: sel_byte = cfg.device_address[23:16];
      POS_ADDR_1: sel_byte = cfg.device_address[15:8];
      POS_ADDR_0: sel_byte = cfg.device_address[7:0];
      POS_TYPE:   sel_byte = item.ptype;
      POS_LEN_HI: sel_byte = item.len[15:8];
      POS_LEN_LO: sel_byte = item.len[7:0];
      POS_DATA:   sel_byte = item.data;
      POS_SUM_HI: sel_byte = item.sum[15:8];
      POS_SUM_LO: sel_byte = item.sum[7:0];
      default:    sel_byte = item.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (step)
      out_valid <= 1'b1;
    else if (!out_stall)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte   <= sel_byte;
      run_last   <= stat.last;
      packet_end <= (stat.pos == POS_SUM_LO);
    end
  end

`ifndef NO_ASSERTIONS
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> run_last)
    else $error("packet end without request end");
`endif

endmodule

// ----- sv/sensor_command_packet_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_command_packet_framer
// Serializes sensor command packets, one payload byte per input request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries packet_type, payload_count and
//   data_byte. A request while no packet is open starts a packet; type and
//   count are read only then. Output channel (out_valid/out_stall) delivers
//   the packet one byte at a time; run_last marks a request's final byte,
//   packet_end the low checksum byte.
//   Config port (cfg_valid/cfg_ready, always ready) writes device_address
//   (index 0) and start_code (index 1); write only while idle.
//   Flow: an accepted request goes to the request register and its bytes to the
//   output register. An opening request emits 9 header bytes before its data
//   byte; a closing one adds two checksum bytes. The output gives one byte per
//   cycle while out_stall is low. Mid-packet requests sustain one per cycle
//   while the output does not stall; the next request is taken as the previous
//   one's last byte moves to the output register.
//   Reset (rst, synchronous) closes any open packet, empties both registers
//   and restores the default address 0xFFFFFFFF and start code 0xEF01.
//   A stalled output holds its byte and backs up into in_stall.
// ----------------------------------------------------------------------------
module sensor_command_packet_framer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [scpf_pkg::BYTE_W-1:0]     packet_type,
  input  logic [scpf_pkg::COUNT_W-1:0]    payload_count,
  input  logic [scpf_pkg::BYTE_W-1:0]     data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [scpf_pkg::BYTE_W-1:0]     out_byte,
  output logic                            run_last,
  output logic                            packet_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scpf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scpf_pkg::*;

  cfg_t       cfg;
  item_t      item;
  item_stat_t stat;
  logic       step;

  scpf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scpf_ingest u_ingest (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .packet_type   (packet_type),
    .payload_count (payload_count),
    .data_byte     (data_byte),
    .step          (step),
    .item          (item),
    .stat          (stat)
  );

  scpf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .stat       (stat),
    .step       (step),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .packet_end (packet_end)
  );

endmodule

// ----- bench/sensor_command_packet_framer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_command_packet_framer_tb
// Drives payload-byte requests into the framer with random gaps and output
// stalls. A local packet builder predicts every line byte with its run_last
// and packet_end flags, and the output monitor checks each one in order.
// ----------------------------------------------------------------------------
module sensor_command_packet_framer_tb;
  import scpf_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [BYTE_W-1:0]  ptype;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  data;
  } sensor_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              run_last;
    logic              packet_end;
  } line_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     packet_type = '0;
  logic [COUNT_W-1:0]    payload_count = '0;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  run_last;
  logic                  packet_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sensor_req_t pending_reqs[$];
  line_byte_t  expected_bytes[$];
  sensor_req_t next_req;
  line_byte_t  want;

  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;
  int   err_count = 0;
  int   hold_left = 0;
  logic press_go = 1'b0;
  logic press_done = 1'b0;

  // packet builder state
  logic [ADDR_W-1:0]  model_addr = 32'hFFFF_FFFF;
  logic [CODE_W-1:0]  model_code = 16'hEF01;
  logic [COUNT_W-1:0] open_left = '0;
  logic [SUM_W-1:0]   csum = '0;

  sensor_command_packet_framer u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .packet_type   (packet_type),
    .payload_count (payload_count),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .packet_end    (packet_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_line(input logic [BYTE_W-1:0] b, input logic last,
                                    input logic pend);
    expected_bytes.push_back('{value: b, run_last: last, packet_end: pend});
  endfunction

  // expected line bytes for one accepted request
  function automatic void frame_request(input logic [BYTE_W-1:0] ptype,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [BYTE_W-1:0] dat);
    logic [COUNT_W-1:0] n;
    logic [LEN_W-1:0]   len;
    if (open_left == '0) begin
      if (cnt == '0) n = COUNT_W'(1);
      else if (cnt > COUNT_W'(MAX_PAYLOAD)) n = COUNT_W'(MAX_PAYLOAD);
      else n = cnt;
      len = LEN_W'(n) + 16'd2;
      push_line(model_code[15:8], 1'b0, 1'b0);
      push_line(model_code[7:0], 1'b0, 1'b0);
      push_line(model_addr[31:24], 1'b0, 1'b0);
      push_line(model_addr[23:16], 1'b0, 1'b0);
      push_line(model_addr[15:8], 1'b0, 1'b0);
      push_line(model_addr[7:0], 1'b0, 1'b0);
      push_line(ptype, 1'b0, 1'b0);
      push_line(len[15:8], 1'b0, 1'b0);
      push_line(len[7:0], 1'b0, 1'b0);
      csum = SUM_W'(len[15:8]) + SUM_W'(len[7:0]) + SUM_W'(ptype);
      open_left = n;
    end
    csum = csum + SUM_W'(dat);
    open_left = open_left - COUNT_W'(1);
    push_line(dat, open_left != '0, 1'b0);
    if (open_left == '0) begin
      push_line(csum[15:8], 1'b0, 1'b0);
      push_line(csum[7:0], 1'b1, 1'b1);
      csum = '0;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) frame_request(packet_type, payload_count, data_byte);
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid      <= 1'b1;
          packet_type   <= next_req.ptype;
          payload_count <= next_req.count;
          data_byte     <= next_req.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (press_go && !press_done) begin
      hold_left  <= HOLD_CYCLES;
      press_done <= 1'b1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %02h", $time, out_byte);
        err_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.value) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.value, out_byte);
          err_count++;
        end
        if (run_last !== want.run_last) begin
          $display("%0t: run_last mismatch: expected %0b, actual %0b",
                   $time, want.run_last, run_last);
          err_count++;
        end
        if (packet_end !== want.packet_end) begin
          $display("%0t: packet_end mismatch: expected %0b, actual %0b",
                   $time, want.packet_end, packet_end);
          err_count++;
        end
      end
    end
  end

  function automatic void add_req(input logic [BYTE_W-1:0] t, input logic [COUNT_W-1:0] c,
                                  input logic [BYTE_W-1:0] d);
    pending_reqs.push_back('{ptype: t, count: c, data: d});
  endfunction

  // one whole packet; follow-on requests carry random type and count noise
  function automatic int add_packet(input logic [COUNT_W-1:0] cnt, input bit ones);
    int n;
    n = (cnt == '0) ? 1 : ((cnt > COUNT_W'(MAX_PAYLOAD)) ? MAX_PAYLOAD : int'(cnt));
    for (int i = 0; i < n; i++) begin
      add_req(BYTE_W'($urandom_range(255)),
              (i == 0) ? cnt : COUNT_W'($urandom_range(511)),
              ones ? 8'hFF : BYTE_W'($urandom_range(255)));
    end
    return n;
  endfunction

  // mostly short packets, now and then an oversized count
  function automatic logic [COUNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 80) return COUNT_W'($urandom_range(8, 1));
    if (r < 99) return COUNT_W'($urandom_range(40, 9));
    return COUNT_W'($urandom_range(511, 257));
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0 ||
           hold_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DEVICE_ADDRESS) model_addr = val;
    else model_code = val[CODE_W-1:0];
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct, input int n_items,
                              input bit pressure);
    int added;
    added = 0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (added < n_items) added += add_packet(rand_count(), 1'b0);
    if (pressure) press_go <= 1'b1;
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset register values; single-byte packet, zero count, busy-field noise
    add_req(8'h00, 9'd1, 8'h00);
    add_req(8'hFF, 9'd0, 8'hFF);
    add_req(8'hA5, 9'd3, 8'h5A);
    add_req(8'h3C, 9'h1FF, 8'h00);
    add_req(8'hC3, 9'd0, 8'hFF);
    add_req(8'h01, 9'd2, 8'hFF);
    add_req(8'h00, 9'h100, 8'hFF);
    drain();

    write_reg(REG_DEVICE_ADDRESS, 32'h0000_0000);
    write_reg(REG_START_CODE, 32'h0000_0000);
    add_req(8'h00, 9'd1, 8'h00);
    add_req(8'hFF, 9'd2, 8'h80);
    add_req(8'h7E, 9'd0, 8'h7F);
    drain();

    // registers change while a packet is open: new values show from next header
    write_reg(REG_DEVICE_ADDRESS, 32'hFFFF_FFFF);
    write_reg(REG_START_CODE, 32'h0000_FFFF);
    add_req(8'h96, 9'd4, 8'h11);
    add_req(8'h69, 9'd7, 8'h22);
    drain();
    write_reg(REG_DEVICE_ADDRESS, 32'h1234_5678);
    write_reg(REG_START_CODE, 32'hFFFF_ABCD);
    add_req(8'h0F, 9'd1, 8'h33);
    add_req(8'hF0, 9'd0, 8'h44);
    add_req(8'h5A, 9'd1, 8'hEE);
    drain();

    write_reg(REG_DEVICE_ADDRESS, $urandom());
    write_reg(REG_START_CODE, $urandom());
    random_phase(38, 60, 40, 1'b0);

    // saturated count, all ones: checksum wraps only if the packet type is 0xFD or above
    write_reg(REG_DEVICE_ADDRESS, $urandom());
    write_reg(REG_START_CODE, $urandom());
    void'(add_packet(9'd300, 1'b1));
    random_phase(60, 38, 40, 1'b0);

    write_reg(REG_START_CODE, $urandom());
    write_reg(REG_DEVICE_ADDRESS, $urandom());
    random_phase(0, 0, 40, 1'b0);

    random_phase(0, 0, 20, 1'b1);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
